FILE: src/pbs_pkg.sv
// pbs_pkg: widths, register codes, reset values and helpers shared by the
// projected box select block; no dependencies, compiled first
package pbs_pkg;

  localparam int COORD_W     = 24;                   // signed q8.16 vertex coordinate
  localparam int COEF_W      = 16;                   // signed q4.12 coefficient / corner
  localparam int REG_W       = 64;                   // packed config register
  localparam int PROD_W      = COORD_W + COEF_W;     // exact coordinate * coefficient
  localparam int CLIP_W      = PROD_W + 2;           // sum of three products plus constant
  localparam int CONST_SHIFT = 16;                   // q4.12 constant moved to 28 fraction bits
  localparam int FRAC_SHIFT  = 12;                   // clip * 4096 before the divide
  localparam int MAG_W       = CLIP_W;               // magnitude of a clip value
  localparam int NUM_W       = MAG_W + FRAC_SHIFT;   // dividend magnitude
  localparam int DEN_W       = MAG_W;                // divisor magnitude
  localparam int QUOT_W      = 16;                   // quotient bits resolved one per stage
  localparam int CMP_W       = DEN_W + QUOT_W;       // room for the divisor shifted fully
  localparam int DIV_LAT     = QUOT_W + 2;           // overflow stage, bit stages, clamp stage
  localparam int CFG_IDX_W   = 8;
  localparam int FIELD_W     = 16;                   // width of the index and result ports

  localparam logic signed [COEF_W-1:0] Q_MAX = 16'sh7FFF;
  localparam logic signed [COEF_W-1:0] Q_MIN = 16'sh8000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_X   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_Y   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_W   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CORNERS = 8'd3;

  // reset contents give the identity matrix and a degenerate box at the origin
  localparam logic [REG_W-1:0] ROW_X_RESET   = 64'h0000_0000_0000_1000;
  localparam logic [REG_W-1:0] ROW_Y_RESET   = 64'h0000_0000_1000_0000;
  localparam logic [REG_W-1:0] ROW_W_RESET   = 64'h1000_0000_0000_0000;
  localparam logic [REG_W-1:0] CORNERS_RESET = 64'h0000_0000_0000_0000;

  // signed 16-bit lane k of a packed register
  function automatic logic signed [COEF_W-1:0] lane(input logic [REG_W-1:0] r,
                                                    input int k);
    return $signed(r[k*COEF_W +: COEF_W]);
  endfunction

  function automatic logic [MAG_W-1:0] magnitude(input logic signed [CLIP_W-1:0] c);
    return c[CLIP_W-1] ? MAG_W'(-c) : MAG_W'(c);
  endfunction

endpackage

FILE: src/pbs_divider.sv
// pbs_divider: pipelined restoring divider, one quotient bit per stage, with a
// signed clamp to 16 bits at the end; depends on pbs_pkg
module pbs_divider (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic [pbs_pkg::NUM_W-1:0]          num,
  input  logic [pbs_pkg::DEN_W-1:0]          den,
  input  logic                               neg,
  output logic                               out_valid,
  output logic signed [pbs_pkg::QUOT_W-1:0]  quot
);

  localparam int STEPS = pbs_pkg::QUOT_W;

  logic                          vld [0:STEPS];
  logic                          ng  [0:STEPS];
  logic                          ov  [0:STEPS];
  logic [pbs_pkg::NUM_W-1:0]     rem [0:STEPS];
  logic [pbs_pkg::DEN_W-1:0]     dv  [0:STEPS];
  logic [pbs_pkg::QUOT_W-1:0]    qb  [0:STEPS];
  logic signed [pbs_pkg::QUOT_W-1:0] sat;
  logic                          big;
  logic                          rest;

  // quotient of 2^16 or more saturates whatever the sign
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rem[0] <= num;
    dv[0]  <= den;
    ng[0]  <= neg;
    qb[0]  <= '0;
    ov[0]  <= pbs_pkg::CMP_W'(num) >= (pbs_pkg::CMP_W'(den) << STEPS);
  end

  for (genvar j = 1; j <= STEPS; j++) begin : g_step
    localparam int K = STEPS - j;
    logic [pbs_pkg::CMP_W-1:0] shifted;
    logic [pbs_pkg::CMP_W-1:0] diff;
    logic                      take;

    assign shifted = pbs_pkg::CMP_W'(dv[j-1]) << K;
    assign take    = pbs_pkg::CMP_W'(rem[j-1]) >= shifted;
    assign diff    = pbs_pkg::CMP_W'(rem[j-1]) - shifted;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else begin
        vld[j] <= vld[j-1];
      end
      rem[j]    <= take ? diff[pbs_pkg::NUM_W-1:0] : rem[j-1];
      dv[j]     <= dv[j-1];
      ng[j]     <= ng[j-1];
      ov[j]     <= ov[j-1];
      qb[j]     <= qb[j-1] | (pbs_pkg::QUOT_W'(take) << K);
    end
  end

  assign big  = qb[STEPS][STEPS-1];
  assign rest = |qb[STEPS][STEPS-2:0];

  always_comb begin
    if (ng[STEPS]) begin
      sat = (ov[STEPS] || (big && rest)) ? pbs_pkg::Q_MIN : -$signed(qb[STEPS]);
    end else begin
      sat = (ov[STEPS] || big) ? pbs_pkg::Q_MAX : $signed(qb[STEPS]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[STEPS];
    end
    quot <= sat;
  end

  // an overflowed positive quotient must leave as the top of the range
  a_pos_clamp: assert property (@(posedge clk) disable iff (rst)
    (vld[STEPS] && ov[STEPS] && !ng[STEPS]) |=> (quot == pbs_pkg::Q_MAX))
    else $error("positive overflow not clamped");

endmodule

FILE: src/projected_box_select_top.sv
// projected_box_select_top: vertex projection through a configured matrix,
// perspective divide and box test; depends on pbs_pkg and pbs_divider
//
// path: the done strobe follows an accepted vertex through 3 arithmetic stages,
//   18 divider stages and the output reg
// throughput: one vertex per cycle while busy is low; results cannot be held off by the receiver
// reset: rst clears all valid bits and restores the identity matrix; busy is high
//   for the first cycle after reset, then stays low
module projected_box_select_top #(
  parameter int INDEX_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // vertex transaction
  input  logic                                  start,
  output logic                                  busy,
  input  logic [pbs_pkg::FIELD_W-1:0]           vertex_index,
  input  logic signed [pbs_pkg::COORD_W-1:0]    pos_x,
  input  logic signed [pbs_pkg::COORD_W-1:0]    pos_y,
  input  logic signed [pbs_pkg::COORD_W-1:0]    pos_z,
  input  logic                                  last_vertex,
  // configuration write transaction
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pbs_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [pbs_pkg::REG_W-1:0]             cfg_data,
  // result transaction, one cycle per strobe
  output logic                                  done,
  output logic [pbs_pkg::FIELD_W-1:0]           result_index,
  output logic                                  inside_res,
  output logic                                  last_result
);

  // only the low index bits survive the mask, and no more than the port carries
  localparam int KEEP_BITS = (INDEX_BITS < pbs_pkg::FIELD_W) ? INDEX_BITS
                                                              : pbs_pkg::FIELD_W;

  typedef struct packed {
    logic [KEEP_BITS-1:0] idx;
    logic                 last;
    logic                 wzero;
  } side_t;

  // configuration registers
  logic [pbs_pkg::REG_W-1:0] row_x;
  logic [pbs_pkg::REG_W-1:0] row_y;
  logic [pbs_pkg::REG_W-1:0] row_w;
  logic [pbs_pkg::REG_W-1:0] corners;

  logic accept;
  logic cfg_write;

  // stage 1: products
  logic                               v1;
  logic [KEEP_BITS-1:0]               idx1;
  logic                               last1;
  logic signed [pbs_pkg::COORD_W-1:0] pos [0:2];
  logic signed [pbs_pkg::PROD_W-1:0]  prod_x [0:2];
  logic signed [pbs_pkg::PROD_W-1:0]  prod_y [0:2];
  logic signed [pbs_pkg::PROD_W-1:0]  prod_w [0:2];

  // stage 2: clip coordinates with 28 fraction bits
  logic                               v2;
  logic [KEEP_BITS-1:0]               idx2;
  logic                               last2;
  logic signed [pbs_pkg::CLIP_W-1:0]  clip_x;
  logic signed [pbs_pkg::CLIP_W-1:0]  clip_y;
  logic signed [pbs_pkg::CLIP_W-1:0]  clip_w;

  // stage 3: magnitudes and signs for the dividers
  logic                               v3;
  side_t                              side3;
  logic [pbs_pkg::NUM_W-1:0]          num_x;
  logic [pbs_pkg::NUM_W-1:0]          num_y;
  logic [pbs_pkg::DEN_W-1:0]          den_w;
  logic                               neg_x;
  logic                               neg_y;

  // divider outputs and the sideband that travels beside them
  logic                               qx_valid;
  logic                               qy_valid;
  logic signed [pbs_pkg::QUOT_W-1:0]  qx;
  logic signed [pbs_pkg::QUOT_W-1:0]  qy;
  side_t                              side [0:pbs_pkg::DIV_LAT-1];
  side_t                              side_out;

  // box bounds, corners put in min/max order
  logic signed [pbs_pkg::COEF_W-1:0]  ax, ay, bx, by;
  logic signed [pbs_pkg::COEF_W-1:0]  min_x, max_x, min_y, max_y;
  logic                               in_box;

  logic [KEEP_BITS-1:0]               idx_out;

  // handshakes: the only stall is busy, a registered copy of rst
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept    = start && !busy;
  assign cfg_ready = !busy;
  assign cfg_write = cfg_valid && cfg_ready;

  // register file, writes beyond the last register fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      row_x   <= pbs_pkg::ROW_X_RESET;
      row_y   <= pbs_pkg::ROW_Y_RESET;
      row_w   <= pbs_pkg::ROW_W_RESET;
      corners <= pbs_pkg::CORNERS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        pbs_pkg::REG_ROW_X:   row_x   <= cfg_data;
        pbs_pkg::REG_ROW_Y:   row_y   <= cfg_data;
        pbs_pkg::REG_ROW_W:   row_w   <= cfg_data;
        pbs_pkg::REG_CORNERS: corners <= cfg_data;
        default: ;
      endcase
    end
  end

  assign pos[0] = pos_x;
  assign pos[1] = pos_y;
  assign pos[2] = pos_z;

  // stage 1: nine 24x16 multiplies straight off the input ports
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    idx1  <= vertex_index[KEEP_BITS-1:0];
    last1 <= last_vertex;
    for (int k = 0; k < 3; k++) begin
      prod_x[k] <= pbs_pkg::PROD_W'(pos[k]) * pbs_pkg::PROD_W'(pbs_pkg::lane(row_x, k));
      prod_y[k] <= pbs_pkg::PROD_W'(pos[k]) * pbs_pkg::PROD_W'(pbs_pkg::lane(row_y, k));
      prod_w[k] <= pbs_pkg::PROD_W'(pos[k]) * pbs_pkg::PROD_W'(pbs_pkg::lane(row_w, k));
    end
  end

  // stage 2: row sums, constant term scaled to the product's fraction bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    idx2   <= idx1;
    last2  <= last1;
    clip_x <= pbs_pkg::CLIP_W'(prod_x[0]) + pbs_pkg::CLIP_W'(prod_x[1])
            + pbs_pkg::CLIP_W'(prod_x[2])
            + (pbs_pkg::CLIP_W'(pbs_pkg::lane(row_x, 3)) <<< pbs_pkg::CONST_SHIFT);
    clip_y <= pbs_pkg::CLIP_W'(prod_y[0]) + pbs_pkg::CLIP_W'(prod_y[1])
            + pbs_pkg::CLIP_W'(prod_y[2])
            + (pbs_pkg::CLIP_W'(pbs_pkg::lane(row_y, 3)) <<< pbs_pkg::CONST_SHIFT);
    clip_w <= pbs_pkg::CLIP_W'(prod_w[0]) + pbs_pkg::CLIP_W'(prod_w[1])
            + pbs_pkg::CLIP_W'(prod_w[2])
            + (pbs_pkg::CLIP_W'(pbs_pkg::lane(row_w, 3)) <<< pbs_pkg::CONST_SHIFT);
  end

  // stage 3: dividend is |clip| * 4096, quotient sign from both operand signs
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    side3.idx   <= idx2;
    side3.last  <= last2;
    side3.wzero <= (clip_w == '0);
    num_x <= {pbs_pkg::magnitude(clip_x), {pbs_pkg::FRAC_SHIFT{1'b0}}};
    num_y <= {pbs_pkg::magnitude(clip_y), {pbs_pkg::FRAC_SHIFT{1'b0}}};
    den_w <= pbs_pkg::magnitude(clip_w);
    neg_x <= clip_x[pbs_pkg::CLIP_W-1] ^ clip_w[pbs_pkg::CLIP_W-1];
    neg_y <= clip_y[pbs_pkg::CLIP_W-1] ^ clip_w[pbs_pkg::CLIP_W-1];
  end

  // two divider lanes, x and y share the same w
  pbs_divider u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .num       (num_x),
    .den       (den_w),
    .neg       (neg_x),
    .out_valid (qx_valid),
    .quot      (qx)
  );

  pbs_divider u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v3),
    .num       (num_y),
    .den       (den_w),
    .neg       (neg_y),
    .out_valid (qy_valid),
    .quot      (qy)
  );

  // sideband delay line matched to the divider depth
  always_ff @(posedge clk) begin
    side[0] <= side3;
    for (int i = 1; i < pbs_pkg::DIV_LAT; i++) begin
      side[i] <= side[i-1];
    end
  end

  assign side_out = side[pbs_pkg::DIV_LAT-1];

  // user keeps corners static while vertices flow (not enforced by the block); ordering is off the pipe
  assign ax    = pbs_pkg::lane(corners, 0);
  assign ay    = pbs_pkg::lane(corners, 1);
  assign bx    = pbs_pkg::lane(corners, 2);
  assign by    = pbs_pkg::lane(corners, 3);
  assign min_x = (ax < bx) ? ax : bx;
  assign max_x = (ax < bx) ? bx : ax;
  assign min_y = (ay < by) ? ay : by;
  assign max_y = (ay < by) ? by : ay;

  // bounds inclusive; a zero w never counts as inside
  assign in_box = !side_out.wzero
               && (min_x <= qx) && (qx <= max_x)
               && (min_y <= qy) && (qy <= max_y);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= qx_valid;
    end
    idx_out     <= side_out.idx;
    inside_res  <= in_box;
    last_result <= side_out.last;
  end

  assign result_index = pbs_pkg::FIELD_W'(idx_out);

  // both divider lanes run in lock step
  a_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    qx_valid == qy_valid)
    else $error("divider lanes out of step");

  // every accepted vertex reaches the divider input through v1, v2 and v3
  a_accept_reaches_div: assert property (@(posedge clk) disable iff (rst)
    accept |=> ##2 v3)
    else $error("accepted vertex lost before divider");

  // a finished quotient always gives a result strobe
  a_result_strobe: assert property (@(posedge clk) disable iff (rst)
    qx_valid |=> done)
    else $error("quotient without result");

  // degenerate w reports outside
  a_wzero_outside: assert property (@(posedge clk) disable iff (rst)
    (qx_valid && side_out.wzero) |=> !inside_res)
    else $error("zero w reported inside");

  // busy only directly after reset
  a_busy_after_reset: assert property (@(posedge clk) disable iff (rst)
    busy |-> $past(rst))
    else $error("busy outside reset recovery");

endmodule
